/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge out of reset.
`define RFB_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rfb assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define RFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfb assertion failed");

`endif

/* rtl/rfb_pkg.sv */
package rfb_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int TW_BITS     = FRAC_BITS + 2;
    localparam int OUT_BITS    = SAMPLE_BITS + 3;
    localparam int PROD_BITS   = SAMPLE_BITS + TW_BITS;
    localparam int PSUM_BITS   = PROD_BITS + 1;
    localparam int X_BITS      = PSUM_BITS - FRAC_BITS;
    localparam int SD_BITS     = X_BITS + 1;
    localparam int K_BITS      = FRAC_BITS + 2;
    localparam int ROT_BITS    = SD_BITS + K_BITS;
    localparam int ROTQ_BITS   = ROT_BITS - FRAC_BITS;
    localparam int FIN_BITS    = ROTQ_BITS + 1;

    localparam int IDX_BITS    = 16;
    localparam int DEST_BITS   = 18;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 8;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_STEP    = IDX_BITS / DIV_STAGES;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PITCH = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GLEN  = 8'd1;

    // sin(60 deg) in Q.FRAC, rounded from a Q24 constant
    localparam longint SIN60_Q24 = 64'd14529495;
    localparam longint K_VAL = (((SIN60_Q24 * 2) >>> (24 - FRAC_BITS)) + 1) >>> 1;
    localparam logic signed [K_BITS-1:0] K_COEF = K_BITS'(K_VAL);

    typedef struct packed {
        logic [CFG_BITS-1:0] pitch;
        logic [CFG_BITS-1:0] glen;
    } cfg_t;

    localparam logic signed [FIN_BITS-1:0] SAT_MAX = FIN_BITS'((64'sd1 <<< (OUT_BITS-1)) - 1);
    localparam logic signed [FIN_BITS-1:0] SAT_MIN = -SAT_MAX - FIN_BITS'(1);

    function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [FIN_BITS-1:0] v);
        logic [OUT_BITS-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[OUT_BITS-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[OUT_BITS-1:0];
        else
            r = v[OUT_BITS-1:0];
        return r;
    endfunction

endpackage

/* rtl/rfb_datapath.sv */
module rfb_datapath
    import rfb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] p0_re,
    input  logic signed [SAMPLE_BITS-1:0] p0_im,
    input  logic signed [SAMPLE_BITS-1:0] p1_re,
    input  logic signed [SAMPLE_BITS-1:0] p1_im,
    input  logic signed [SAMPLE_BITS-1:0] p2_re,
    input  logic signed [SAMPLE_BITS-1:0] p2_im,
    input  logic signed [TW_BITS-1:0]     w1_re,
    input  logic signed [TW_BITS-1:0]     w1_im,
    input  logic signed [TW_BITS-1:0]     w2_re,
    input  logic signed [TW_BITS-1:0]     w2_im,
    output logic                          res_valid,
    output logic [OUT_BITS-1:0]           y0_re,
    output logic [OUT_BITS-1:0]           y0_im,
    output logic [OUT_BITS-1:0]           y1_re,
    output logic [OUT_BITS-1:0]           y1_im,
    output logic [OUT_BITS-1:0]           y2_re,
    output logic [OUT_BITS-1:0]           y2_im
);

    localparam logic signed [PSUM_BITS-1:0] RND_P = PSUM_BITS'(1) <<< (FRAC_BITS-1);
    localparam logic signed [ROT_BITS-1:0]  RND_R = ROT_BITS'(1) <<< (FRAC_BITS-1);

    logic [5:0] v_reg;

    // stage 1: twiddle partial products
    logic signed [PROD_BITS-1:0] m_reg [8];
    logic signed [SAMPLE_BITS-1:0] p0r1_reg, p0i1_reg;
    // stage 2: rounded twiddled points
    logic signed [X_BITS-1:0] x1r_reg, x1i_reg, x2r_reg, x2i_reg;
    logic signed [X_BITS-1:0] x1r_next, x1i_next, x2r_next, x2i_next;
    logic signed [SAMPLE_BITS-1:0] p0r2_reg, p0i2_reg;
    // stage 3: sum and difference
    logic signed [SD_BITS-1:0] sr_reg, si_reg, dr_reg, di_reg;
    logic signed [SAMPLE_BITS-1:0] p0r3_reg, p0i3_reg;
    // stage 4: constant products
    logic signed [ROT_BITS-1:0] hsr_reg, hsi_reg, kdr_reg, kdi_reg;
    logic signed [SD_BITS-1:0] sr4_reg, si4_reg;
    logic signed [SAMPLE_BITS-1:0] p0r4_reg, p0i4_reg;
    // stage 5: rounded rotations
    logic signed [ROTQ_BITS-1:0] a1r_reg, a1i_reg, a2r_reg, a2i_reg;
    logic signed [ROTQ_BITS-1:0] a1r_next, a1i_next, a2r_next, a2i_next;
    logic signed [SD_BITS-1:0] sr5_reg, si5_reg;
    logic signed [SAMPLE_BITS-1:0] p0r5_reg, p0i5_reg;
    // stage 6: final add and saturation
    logic [OUT_BITS-1:0] y0r_reg, y0i_reg, y1r_reg, y1i_reg, y2r_reg, y2i_reg;
    logic [OUT_BITS-1:0] y0r_next, y0i_next, y1r_next, y1i_next, y2r_next, y2i_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], in_valid};
    end

    always_comb
    begin
        logic signed [PSUM_BITS-1:0] t0, t1, t2, t3;
        t0 = PSUM_BITS'(m_reg[0]) - PSUM_BITS'(m_reg[1]) + RND_P;
        t1 = PSUM_BITS'(m_reg[2]) + PSUM_BITS'(m_reg[3]) + RND_P;
        t2 = PSUM_BITS'(m_reg[4]) - PSUM_BITS'(m_reg[5]) + RND_P;
        t3 = PSUM_BITS'(m_reg[6]) + PSUM_BITS'(m_reg[7]) + RND_P;
        x1r_next = t0[PSUM_BITS-1:FRAC_BITS];
        x1i_next = t1[PSUM_BITS-1:FRAC_BITS];
        x2r_next = t2[PSUM_BITS-1:FRAC_BITS];
        x2i_next = t3[PSUM_BITS-1:FRAC_BITS];
    end

    always_comb
    begin
        logic signed [ROT_BITS-1:0] u0, u1, u2, u3;
        u0 = -hsr_reg - kdi_reg + RND_R;
        u1 = -hsi_reg + kdr_reg + RND_R;
        u2 = -hsr_reg + kdi_reg + RND_R;
        u3 = -hsi_reg - kdr_reg + RND_R;
        a1r_next = u0[ROT_BITS-1:FRAC_BITS];
        a1i_next = u1[ROT_BITS-1:FRAC_BITS];
        a2r_next = u2[ROT_BITS-1:FRAC_BITS];
        a2i_next = u3[ROT_BITS-1:FRAC_BITS];
    end

    always_comb
    begin
        y0r_next = sat_out(FIN_BITS'(p0r5_reg) + FIN_BITS'(sr5_reg));
        y0i_next = sat_out(FIN_BITS'(p0i5_reg) + FIN_BITS'(si5_reg));
        y1r_next = sat_out(FIN_BITS'(p0r5_reg) + FIN_BITS'(a1r_reg));
        y1i_next = sat_out(FIN_BITS'(p0i5_reg) + FIN_BITS'(a1i_reg));
        y2r_next = sat_out(FIN_BITS'(p0r5_reg) + FIN_BITS'(a2r_reg));
        y2i_next = sat_out(FIN_BITS'(p0i5_reg) + FIN_BITS'(a2i_reg));
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            m_reg[0] <= PROD_BITS'(p1_re * w1_re);
            m_reg[1] <= PROD_BITS'(p1_im * w1_im);
            m_reg[2] <= PROD_BITS'(p1_re * w1_im);
            m_reg[3] <= PROD_BITS'(p1_im * w1_re);
            m_reg[4] <= PROD_BITS'(p2_re * w2_re);
            m_reg[5] <= PROD_BITS'(p2_im * w2_im);
            m_reg[6] <= PROD_BITS'(p2_re * w2_im);
            m_reg[7] <= PROD_BITS'(p2_im * w2_re);
            p0r1_reg <= p0_re;
            p0i1_reg <= p0_im;
        end
        if (v_reg[0])
        begin
            x1r_reg  <= x1r_next;
            x1i_reg  <= x1i_next;
            x2r_reg  <= x2r_next;
            x2i_reg  <= x2i_next;
            p0r2_reg <= p0r1_reg;
            p0i2_reg <= p0i1_reg;
        end
        if (v_reg[1])
        begin
            sr_reg   <= SD_BITS'(x1r_reg) + SD_BITS'(x2r_reg);
            si_reg   <= SD_BITS'(x1i_reg) + SD_BITS'(x2i_reg);
            dr_reg   <= SD_BITS'(x1r_reg) - SD_BITS'(x2r_reg);
            di_reg   <= SD_BITS'(x1i_reg) - SD_BITS'(x2i_reg);
            p0r3_reg <= p0r2_reg;
            p0i3_reg <= p0i2_reg;
        end
        if (v_reg[2])
        begin
            // multiply by one half is a shift
            hsr_reg  <= ROT_BITS'(sr_reg) <<< (FRAC_BITS-1);
            hsi_reg  <= ROT_BITS'(si_reg) <<< (FRAC_BITS-1);
            kdr_reg  <= ROT_BITS'(dr_reg) * ROT_BITS'(K_COEF);
            kdi_reg  <= ROT_BITS'(di_reg) * ROT_BITS'(K_COEF);
            sr4_reg  <= sr_reg;
            si4_reg  <= si_reg;
            p0r4_reg <= p0r3_reg;
            p0i4_reg <= p0i3_reg;
        end
        if (v_reg[3])
        begin
            a1r_reg  <= a1r_next;
            a1i_reg  <= a1i_next;
            a2r_reg  <= a2r_next;
            a2i_reg  <= a2i_next;
            sr5_reg  <= sr4_reg;
            si5_reg  <= si4_reg;
            p0r5_reg <= p0r4_reg;
            p0i5_reg <= p0i4_reg;
        end
        if (v_reg[4])
        begin
            y0r_reg <= y0r_next;
            y0i_reg <= y0i_next;
            y1r_reg <= y1r_next;
            y1i_reg <= y1i_next;
            y2r_reg <= y2r_next;
            y2i_reg <= y2i_next;
        end
    end

    assign res_valid = v_reg[5];
    assign y0_re = y0r_reg;
    assign y0_im = y0i_reg;
    assign y1_re = y1r_reg;
    assign y1_im = y1i_reg;
    assign y2_re = y2r_reg;
    assign y2_im = y2i_reg;

endmodule

/* rtl/rfb_index.sv */
module rfb_index
    import rfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [IDX_BITS-1:0]   bfly_index,
    input  cfg_t                  cfg,
    output logic                  res_valid,
    output logic [DEST_BITS-1:0]  dest0,
    output logic [DEST_BITS-1:0]  dest1,
    output logic [DEST_BITS-1:0]  dest2
);

    logic [5:0] v_reg;
    logic [DIV_STAGES-1:0] stg_en;

    // restoring divider, DIV_STEP quotient bits per stage
    logic [IDX_BITS-1:0] num_reg [DIV_STAGES];
    logic [IDX_BITS-1:0] quo_reg [DIV_STAGES];
    logic [IDX_BITS-1:0] rem_reg [DIV_STAGES];
    logic [IDX_BITS-1:0] num_next [DIV_STAGES];
    logic [IDX_BITS-1:0] quo_next [DIV_STAGES];
    logic [IDX_BITS-1:0] rem_next [DIV_STAGES];
    logic [DEST_BITS-1:0] dex_reg;
    logic [DEST_BITS-1:0] d0_reg, d1_reg, d2_reg;
    logic [CFG_BITS-1:0] pitch;
    logic [2*CFG_BITS:0] dex_full;

    // zero pitch behaves as one
    assign pitch = (cfg.pitch == '0) ? CFG_BITS'(1) : cfg.pitch;

    assign stg_en = {v_reg[DIV_STAGES-2:0], in_valid};

    always_comb
    begin
        logic [IDX_BITS-1:0] n, q;
        logic [IDX_BITS:0] r;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                n = bfly_index;
                q = '0;
                r = '0;
            end
            else
            begin
                n = num_reg[s-1];
                q = quo_reg[s-1];
                r = {1'b0, rem_reg[s-1]};
            end
            for (int b = 0; b < DIV_STEP; b++)
            begin
                r = {r[IDX_BITS-1:0], n[IDX_BITS-1]};
                n = {n[IDX_BITS-2:0], 1'b0};
                if (r >= {1'b0, pitch})
                begin
                    r = r - {1'b0, pitch};
                    q = {q[IDX_BITS-2:0], 1'b1};
                end
                else
                    q = {q[IDX_BITS-2:0], 1'b0};
            end
            num_next[s] = n;
            quo_next[s] = q;
            rem_next[s] = r[IDX_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], in_valid};
    end

    assign dex_full = (2*CFG_BITS+1)'(quo_reg[DIV_STAGES-1] * cfg.glen)
                    + (2*CFG_BITS+1)'(rem_reg[DIV_STAGES-1]);

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (stg_en[s])
            begin
                num_reg[s] <= num_next[s];
                quo_reg[s] <= quo_next[s];
                rem_reg[s] <= rem_next[s];
            end
        end
        if (v_reg[DIV_STAGES-1])
            dex_reg <= dex_full[DEST_BITS-1:0];
        if (v_reg[DIV_STAGES])
        begin
            d0_reg <= dex_reg;
            d1_reg <= dex_reg + DEST_BITS'(pitch);
            d2_reg <= dex_reg + DEST_BITS'({pitch, 1'b0});
        end
    end

    assign res_valid = v_reg[5];
    assign dest0 = d0_reg;
    assign dest1 = d1_reg;
    assign dest2 = d2_reg;

endmodule

/* rtl/radix3_fft_butterfly_unit.sv */
// Radix-3 FFT butterfly, fixed point (24-bit samples, Q2.16 twiddles).
// Input: a request is taken on a clock edge with start high and busy low;
// all payload ports are sampled on that edge.
// Output: three results per request, X0, X1, X2, on consecutive cycles, each
// marked by result_valid for one cycle; last is high with X2. Values are
// saturated to 27 bits, dest_index is truncated to 18 bits.
// Path: X0 passes six pipeline stages, the first loaded on the accepting
// edge, and then the output register before it reaches the result ports;
// X1 and X2 follow it on consecutive cycles.
// Throughput: limited by the single result port; busy goes high after each
// accepted request, and no new request is taken while it is high.
// Config: write store_pitch (index 0) or group_length (index 1) over
// cfg_valid/cfg_ready/cfg_index/cfg_data while no request is in flight;
// other indexes are dropped. cfg_ready is always high.
// Reset: clears the pipeline valids, the output sequencer and busy, and
// sets store_pitch to 1 and group_length to 3.
// The receiver cannot stall; results must be taken as they appear.
`include "assert_macros.svh"

module radix3_fft_butterfly_unit
    import rfb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] p0_re,
    input  logic signed [SAMPLE_BITS-1:0] p0_im,
    input  logic signed [SAMPLE_BITS-1:0] p1_re,
    input  logic signed [SAMPLE_BITS-1:0] p1_im,
    input  logic signed [SAMPLE_BITS-1:0] p2_re,
    input  logic signed [SAMPLE_BITS-1:0] p2_im,
    input  logic signed [TW_BITS-1:0]     w1_re,
    input  logic signed [TW_BITS-1:0]     w1_im,
    input  logic signed [TW_BITS-1:0]     w2_re,
    input  logic signed [TW_BITS-1:0]     w2_im,
    input  logic [IDX_BITS-1:0]           bfly_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_data,
    output logic                          result_valid,
    output logic signed [OUT_BITS-1:0]    out_re,
    output logic signed [OUT_BITS-1:0]    out_im,
    output logic [DEST_BITS-1:0]          dest_index,
    output logic                          last
);

    typedef enum logic [1:0] {IDLE, SEND1, SEND2} seq_t;

    seq_t                state_reg;
    logic [1:0]          hold_reg;
    cfg_t                cfg_reg;
    logic                accept;
    logic                dp_valid, ix_valid;
    logic [OUT_BITS-1:0] y0r, y0i, y1r, y1i, y2r, y2i;
    logic [DEST_BITS-1:0] d0, d1, d2;
    logic [OUT_BITS-1:0] b1r_reg, b1i_reg, b2r_reg, b2i_reg;
    logic [DEST_BITS-1:0] bd1_reg, bd2_reg;
    logic                rv_reg, last_reg;
    logic [OUT_BITS-1:0] ore_reg, oim_reg;
    logic [DEST_BITS-1:0] odx_reg;

    assign accept    = start && !busy;
    assign busy      = (hold_reg != 2'd0);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg      <= 2'd0;
            cfg_reg.pitch <= CFG_BITS'(1);
            cfg_reg.glen  <= CFG_BITS'(3);
        end
        else
        begin
            if (accept)
                hold_reg <= 2'd2;
            else if (hold_reg != 2'd0)
                hold_reg <= hold_reg - 2'd1;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PITCH: cfg_reg.pitch <= cfg_data;
                    CFG_GLEN:  cfg_reg.glen  <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    rfb_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .p0_re    (p0_re),
        .p0_im    (p0_im),
        .p1_re    (p1_re),
        .p1_im    (p1_im),
        .p2_re    (p2_re),
        .p2_im    (p2_im),
        .w1_re    (w1_re),
        .w1_im    (w1_im),
        .w2_re    (w2_re),
        .w2_im    (w2_im),
        .res_valid(dp_valid),
        .y0_re    (y0r),
        .y0_im    (y0i),
        .y1_re    (y1r),
        .y1_im    (y1i),
        .y2_re    (y2r),
        .y2_im    (y2i)
    );

    rfb_index u_ix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .bfly_index(bfly_index),
        .cfg       (cfg_reg),
        .res_valid (ix_valid),
        .dest0     (d0),
        .dest1     (d1),
        .dest2     (d2)
    );

    // output sequencer: X0 straight through, X1 and X2 from the holding buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            rv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    rv_reg   <= dp_valid;
                    last_reg <= 1'b0;
                    if (dp_valid)
                    begin
                        ore_reg   <= y0r;
                        oim_reg   <= y0i;
                        odx_reg   <= d0;
                        b1r_reg   <= y1r;
                        b1i_reg   <= y1i;
                        b2r_reg   <= y2r;
                        b2i_reg   <= y2i;
                        bd1_reg   <= d1;
                        bd2_reg   <= d2;
                        state_reg <= SEND1;
                    end
                end
                SEND1:
                begin
                    rv_reg    <= 1'b1;
                    last_reg  <= 1'b0;
                    ore_reg   <= b1r_reg;
                    oim_reg   <= b1i_reg;
                    odx_reg   <= bd1_reg;
                    state_reg <= SEND2;
                end
                SEND2:
                begin
                    rv_reg    <= 1'b1;
                    last_reg  <= 1'b1;
                    ore_reg   <= b2r_reg;
                    oim_reg   <= b2i_reg;
                    odx_reg   <= bd2_reg;
                    state_reg <= IDLE;
                end
                default:
                begin
                    rv_reg    <= 1'b0;
                    last_reg  <= 1'b0;
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign result_valid = rv_reg;
    assign out_re       = ore_reg;
    assign out_im       = oim_reg;
    assign dest_index   = odx_reg;
    assign last         = last_reg;

    `RFB_ASSERT(a_lanes_aligned, dp_valid == ix_valid)
    `RFB_ASSERT(a_no_overlap, !dp_valid || (state_reg == IDLE))
    `RFB_ASSERT_NEXT(a_hold_after_accept, accept, busy && !accept)
    `RFB_ASSERT_NEXT(a_last_follows, last_reg, !last_reg)

endmodule
